// ===== rtl/core/mct_pkg.sv =====
`default_nettype none
package mct_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  // most expiry beats posted by one tick
  localparam int MAX_OUT = 16;
  localparam int POST_W = $clog2(MAX_OUT + 1);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_EXPIRY = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_t;

  // APB word index of each register
  typedef enum logic {
    REG_EVENTS_ENABLE = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic        periodic;
    logic [7:0]  dest;
    logic [7:0]  evt;
    logic [31:0] period;
    logic [31:0] remaining;
  } slot_rec_t;

endpackage
`default_nettype wire

// ===== rtl/core/mct_slot_mem.sv =====
`default_nettype none
module mct_slot_mem
  import mct_pkg::*;
#(
  parameter int DEPTH = NUM_TIMERS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic      clk,
  input  wire logic      we,
  input  wire logic [AW-1:0] waddr,
  input  wire slot_rec_t wdata,
  input  wire logic [AW-1:0] raddr,
  output slot_rec_t      rdata
);

  slot_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/mct_apb_regs.sv =====
`default_nettype none
module mct_apb_regs
  import mct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             events_enable
);

  logic     wr_en;
  reg_idx_t word_idx;

  assign pready   = 1'b1;
  assign word_idx = reg_idx_t'(paddr[2]);
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      events_enable <= 1'b0;
    end else if (wr_en && word_idx == REG_EVENTS_ENABLE) begin
      events_enable <= pwdata[0];
    end
  end

  always_comb begin
    unique case (word_idx)
      REG_EVENTS_ENABLE: prdata = {31'd0, events_enable};
      default:           prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/mct_seq.sv =====
`default_nettype none
module mct_seq
  import mct_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int AW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        events_enable,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  timer_sel,
  input  wire logic [7:0]  dest_object,
  input  wire logic [7:0]  event_code,
  input  wire logic [31:0] period_ticks,
  input  wire logic        periodic,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output slot_rec_t        mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  wire slot_rec_t   mem_rdata,
  output logic             result_strobe,
  output logic [1:0]       kind,
  output logic             is_running,
  output logic [7:0]       fired_dest,
  output logic [7:0]       fired_event,
  output logic             last
);

  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  state_t state, state_next;
  cmd_t   cmd_c;

  logic [NUM_TIMERS-1:0] active, active_next;
  logic [CNT_W-1:0]      cnt;
  logic                  pv;
  logic [AW-1:0]         pidx;
  logic [POST_W-1:0]     posted;
  logic                  held_vld;
  logic [7:0]            held_dest, held_evt;

  logic        accept, in_range, walk_end;
  logic [AW-1:0] sel_idx;
  logic        hit, expired, post;
  logic [31:0] rem_dec;

  logic        emit;
  kind_t       emit_kind;
  logic        emit_run, emit_last;
  logic [7:0]  emit_dest, emit_evt;

  assign cmd_c    = cmd_t'(cmd);
  assign busy     = (state != ST_IDLE);
  assign accept   = start && (state == ST_IDLE);
  assign in_range = {1'b0, timer_sel} < 9'(NUM_TIMERS);
  assign sel_idx  = timer_sel[AW-1:0];
  assign walk_end = (cnt == CNT_W'(NUM_TIMERS));

  assign mem_raddr = cnt[AW-1:0];
  assign rem_dec   = mem_rdata.remaining - 32'd1;
  assign hit       = pv && active[pidx];
  assign expired   = hit && (rem_dec == 32'd0);
  assign post      = expired && events_enable && (posted < POST_W'(MAX_OUT));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && cmd_c == CMD_TICK) state_next = ST_WALK;
      ST_WALK: if (walk_end) state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory write, active flags and result beat
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = pidx;
    mem_wdata   = mem_rdata;
    active_next = active;
    emit        = 1'b0;
    emit_kind   = KIND_EMPTY;
    emit_run    = 1'b0;
    emit_last   = 1'b1;
    emit_dest   = 8'd0;
    emit_evt    = 8'd0;

    if (accept && cmd_c == CMD_START && in_range) begin
      mem_we      = 1'b1;
      mem_waddr   = sel_idx;
      mem_wdata   = '{periodic: periodic, dest: dest_object, evt: event_code,
                      period: period_ticks, remaining: period_ticks};
      active_next[sel_idx] = 1'b1;
    end else if (accept && cmd_c == CMD_STOP && in_range) begin
      active_next[sel_idx] = 1'b0;
    end else if (hit) begin
      mem_we = 1'b1;
      mem_wdata.remaining = (expired && mem_rdata.periodic) ? mem_rdata.period : rem_dec;
      if (expired && !mem_rdata.periodic) begin
        active_next[pidx] = 1'b0;
      end
    end

    if (accept && cmd_c == CMD_QUERY) begin
      emit      = 1'b1;
      emit_kind = KIND_QUERY;
      emit_run  = in_range && active[sel_idx];
    end else if (post && held_vld) begin
      // a later expiry proves the held one is not the final beat
      emit      = 1'b1;
      emit_kind = KIND_EXPIRY;
      emit_last = 1'b0;
      emit_dest = held_dest;
      emit_evt  = held_evt;
    end else if (state == ST_FIN) begin
      emit = 1'b1;
      if (held_vld) begin
        emit_kind = KIND_EXPIRY;
        emit_dest = held_dest;
        emit_evt  = held_evt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active        <= '0;
      cnt           <= '0;
      pv            <= 1'b0;
      posted        <= '0;
      held_vld      <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      active        <= active_next;
      pv            <= (state == ST_WALK) && !walk_end;
      result_strobe <= emit;
      if (accept) begin
        cnt    <= '0;
        posted <= '0;
      end else if (state == ST_WALK) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (post) begin
        posted   <= posted + POST_W'(1);
        held_vld <= 1'b1;
      end else if (state == ST_FIN) begin
        held_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= cnt[AW-1:0];
    if (post) begin
      held_dest <= mem_rdata.dest;
      held_evt  <= mem_rdata.evt;
    end
    if (emit) begin
      kind        <= emit_kind;
      is_running  <= emit_run;
      fired_dest  <= emit_dest;
      fired_event <= emit_evt;
      last        <= emit_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/multi_channel_countdown_timer_core.sv =====
`default_nettype none
// Bank of NUM_TIMERS countdown timers kept in one synchronous slot memory.
// Start, stop and query leave busy low; a query answer beat shows on the
// result ports the cycle after it is taken. A tick walks every slot through a
// read-modify-write of the slot memory, one slot a cycle, and keeps busy high
// for the whole walk; expiry beats come out in ascending slot order, each
// once the next expiry is found or the walk ends, one cycle long behind
// result_strobe; the final beat (last = 1) appears the cycle busy drops. Beats
// cannot be held off: the receiver must take each one in the cycle it is shown.
module multi_channel_countdown_timer_core
  import mct_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  timer_sel,
  input  wire logic [7:0]  dest_object,
  input  wire logic [7:0]  event_code,
  input  wire logic [31:0] period_ticks,
  input  wire logic        periodic,
  output logic             result_strobe,
  output logic [1:0]       kind,
  output logic             is_running,
  output logic [7:0]       fired_dest,
  output logic [7:0]       fired_event,
  output logic             last
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic          events_enable;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  slot_rec_t     mem_wdata, mem_rdata;

  mct_apb_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .events_enable (events_enable)
  );

  mct_slot_mem #(
    .DEPTH (NUM_TIMERS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mct_seq #(
    .NUM_TIMERS (NUM_TIMERS),
    .AW         (AW)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .events_enable (events_enable),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .timer_sel     (timer_sel),
    .dest_object   (dest_object),
    .event_code    (event_code),
    .period_ticks  (period_ticks),
    .periodic      (periodic),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .result_strobe (result_strobe),
    .kind          (kind),
    .is_running    (is_running),
    .fired_dest    (fired_dest),
    .fired_event   (fired_event),
    .last          (last)
  );

endmodule
`default_nettype wire

// ===== rtl/core/mct_checker.sv =====
`default_nettype none
module mct_checker
  import mct_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] cmd,
  input wire logic       result_strobe,
  input wire logic [1:0] kind,
  input wire logic       last
);

  // a query is answered in the very next cycle with a single final beat
  a_query_answer: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == CMD_QUERY |=>
      result_strobe && kind == KIND_QUERY && last)
    else $error("query not answered next cycle");

  // start and stop post nothing
  a_start_stop_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd == CMD_START || cmd == CMD_STOP) |=> !result_strobe)
    else $error("beat after start or stop");

  // a tick holds the block busy while it walks
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == CMD_TICK |=> busy)
    else $error("tick did not raise busy");

  // non-final expiry beats only come mid-walk
  a_mid_beat_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> busy && kind == KIND_EXPIRY)
    else $error("non-final beat outside a walk");

  // the final beat of a tick lands as busy drops
  a_tick_end: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last && kind != KIND_QUERY |-> !busy && $past(busy))
    else $error("tick final beat misplaced");

endmodule

bind multi_channel_countdown_timer_core mct_checker u_mct_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .cmd           (cmd),
  .result_strobe (result_strobe),
  .kind          (kind),
  .last          (last)
);
`default_nettype wire
